[rtl/hcpf_pkg.sv]
// Shared types, constants and helpers for the Hertz contact pair force block.
`timescale 1ns / 1ps

package hcpf_pkg;

    localparam logic [15:0] SCALE_RESET = 16'd4096;
    localparam logic [31:0] STEP_MAX = 32'hFFFF_FFFF;
    localparam logic [46:0] FORCE_MAX = 47'h7FFF_FFFF_FFFF;
    localparam logic [63:0] K_HERTZ = 64'd17895697;
    localparam logic [63:0] K_ENERGY = 64'd6710886;
    localparam logic [63:0] K_PI = 64'd52680458;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    localparam logic [6:0] MUL_STEPS = 7'd5;
    localparam logic [6:0] ROOT32_STEPS = 7'd32;
    localparam logic [6:0] ROOT64_STEPS = 7'd64;
    localparam logic [6:0] DIV_RGEOM_STEPS = 7'd72;
    localparam logic [6:0] DIV_STEP_STEPS = 7'd100;
    localparam logic [6:0] DIV_FORCE_STEPS = 7'd96;

    typedef struct packed {
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [30:0] rad_first;
        logic [30:0] rad_second;
        logic        bonded;
        logic [31:0] mass;
        logic [31:0] modulus;
        logic        sweep;
    } item_t;

    typedef struct packed {
        logic [1:0]   op;
        logic [127:0] a;
        logic [63:0]  b;
        logic [6:0]   count;
    } iter_cmd_t;

    function automatic logic [63:0] sat_shr16(input logic [127:0] p);
        logic [63:0] v;
        v = (|p[127:80]) ? 64'hFFFF_FFFF_FFFF_FFFF : p[79:16];
        return v;
    endfunction

    function automatic logic [63:0] sat_shr24(input logic [127:0] p);
        logic [63:0] v;
        v = (|p[127:88]) ? 64'hFFFF_FFFF_FFFF_FFFF : p[87:24];
        return v;
    endfunction

endpackage

[rtl/hcpf_iter.sv]
// Shared iterative unit: 64x64 multiply, 128/64 divide, 128-bit square root.
`timescale 1ns / 1ps

module hcpf_iter
    import hcpf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  iter_cmd_t    cmd,
    output logic         done,
    output logic [127:0] res,
    output logic         rem_zero
);

    logic         busy_reg;
    logic         done_reg;
    logic [1:0]   op_reg;
    logic [6:0]   cnt_reg;
    logic [6:0]   last_reg;
    logic [127:0] num_reg;
    logic [63:0]  den_reg;
    logic [64:0]  rem_reg;
    logic [127:0] res_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;

    logic [64:0]  div_trial;
    logic [64:0]  div_diff;
    logic         div_ge;
    logic [66:0]  sq_t;
    logic [66:0]  sq_trial;
    logic [66:0]  sq_diff;
    logic         sq_ge;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp_prod;
    logic [127:0] pp_shifted;
    logic         last_step;

    assign div_trial = {rem_reg[63:0], num_reg[127]};
    assign div_ge = div_trial >= {1'b0, den_reg};
    assign div_diff = div_trial - {1'b0, den_reg};

    assign sq_t = {rem_reg, num_reg[127:126]};
    assign sq_trial = {1'b0, res_reg[63:0], 2'b01};
    assign sq_ge = sq_t >= sq_trial;
    assign sq_diff = sq_t - sq_trial;

    assign a_half = cnt_reg[1] ? num_reg[63:32] : num_reg[31:0];
    assign b_half = cnt_reg[0] ? den_reg[63:32] : den_reg[31:0];
    assign pp_prod = a_half * b_half;

    always_comb
    begin
        unique case (pp_sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    assign last_step = busy_reg && (cnt_reg == last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
                busy_reg <= 1'b1;
            else if (last_step)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg <= cmd.op;
            cnt_reg <= 7'd0;
            last_reg <= cmd.count - 7'd1;
            num_reg <= cmd.a;
            den_reg <= cmd.b;
            rem_reg <= 65'd0;
            res_reg <= 128'd0;
            pp_sh_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            case (op_reg)
                OP_MUL:
                begin
                    if (!cnt_reg[2])
                    begin
                        pp_reg <= pp_prod;
                        pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                    end
                    if (cnt_reg != 7'd0)
                        res_reg <= res_reg + pp_shifted;
                end
                OP_DIV:
                begin
                    num_reg <= {num_reg[126:0], 1'b0};
                    res_reg <= {res_reg[126:0], div_ge};
                    rem_reg <= {1'b0, div_ge ? div_diff[63:0] : div_trial[63:0]};
                end
                OP_SQRT:
                begin
                    num_reg <= {num_reg[125:0], 2'b00};
                    res_reg <= {res_reg[126:0], sq_ge};
                    rem_reg <= sq_ge ? sq_diff[64:0] : sq_t[64:0];
                end
                default:
                begin
                    res_reg <= res_reg;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res = res_reg;
    assign rem_zero = (rem_reg == 65'd0);

endmodule

[rtl/hcpf_front.sv]
// Front end: request intake, sign/magnitude split and bonded-pair test.
`timescale 1ns / 1ps

module hcpf_front
    import hcpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sep_x,
    input  logic [31:0] sep_y,
    input  logic [31:0] sep_z,
    input  logic [30:0] radius_first,
    input  logic [30:0] radius_second,
    input  logic        same_kind,
    input  logic [31:0] init_dist_sq,
    input  logic [30:0] sph_sum,
    input  logic [31:0] mass_sum,
    input  logic [31:0] modulus,
    input  logic        sweep_start,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    logic        stage_valid_reg;
    logic        stage_valid_next;
    logic [31:0] sx_reg;
    logic [31:0] sy_reg;
    logic [31:0] sz_reg;
    logic [30:0] r1_reg;
    logic [30:0] r2_reg;
    logic        same_reg;
    logic [31:0] init_reg;
    logic [30:0] sph_reg;
    logic [31:0] mass_reg;
    logic [31:0] mod_reg;
    logic        sweep_reg;

    logic        accept;
    logic [61:0] sph_sq;

    assign in_stall = stage_valid_reg && q_full;
    assign accept = in_valid && !in_stall;
    assign q_push = stage_valid_reg && !q_full;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (q_push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= sep_x;
            sy_reg <= sep_y;
            sz_reg <= sep_z;
            r1_reg <= radius_first;
            r2_reg <= radius_second;
            same_reg <= same_kind;
            init_reg <= init_dist_sq;
            sph_reg <= sph_sum;
            mass_reg <= mass_sum;
            mod_reg <= modulus;
            sweep_reg <= sweep_start;
        end
    end

    assign sph_sq = sph_reg * sph_reg;

    always_comb
    begin
        q_item.neg_x = sx_reg[31];
        q_item.neg_y = sy_reg[31];
        q_item.neg_z = sz_reg[31];
        q_item.mag_x = sx_reg[31] ? (~sx_reg + 32'd1) : sx_reg;
        q_item.mag_y = sy_reg[31] ? (~sy_reg + 32'd1) : sy_reg;
        q_item.mag_z = sz_reg[31] ? (~sz_reg + 32'd1) : sz_reg;
        q_item.rad_first = r1_reg;
        q_item.rad_second = r2_reg;
        q_item.bonded = same_reg && ({6'd0, init_reg, 24'd0} < sph_sq);
        q_item.mass = mass_reg;
        q_item.modulus = mod_reg;
        q_item.sweep = sweep_reg;
    end

endmodule

[rtl/hcpf_queue.sv]
// Two-entry queue between the front end and the force sequencer.
`timescale 1ns / 1ps

module hcpf_queue
    import hcpf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/hcpf_back.sv]
// Force sequencer: contact test, Hertz force, energy, time step, output register.
`timescale 1ns / 1ps

module hcpf_back
    import hcpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] contact_scale,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        touching,
    output logic [47:0] force_x,
    output logic [47:0] force_y,
    output logic [47:0] force_z,
    output logic [46:0] pair_energy,
    output logic [31:0] crit_step,
    output logic [31:0] min_step
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RI   = 5'd1;
    localparam logic [4:0] S_RJ   = 5'd2;
    localparam logic [4:0] S_SQX  = 5'd3;
    localparam logic [4:0] S_SQY  = 5'd4;
    localparam logic [4:0] S_SQZ  = 5'd5;
    localparam logic [4:0] S_ROOT = 5'd6;
    localparam logic [4:0] S_CUT  = 5'd7;
    localparam logic [4:0] S_PRR  = 5'd8;
    localparam logic [4:0] S_DRG  = 5'd9;
    localparam logic [4:0] S_PDR  = 5'd10;
    localparam logic [4:0] S_RTG  = 5'd11;
    localparam logic [4:0] S_F1   = 5'd12;
    localparam logic [4:0] S_F2   = 5'd13;
    localparam logic [4:0] S_F3   = 5'd14;
    localparam logic [4:0] S_E1   = 5'd15;
    localparam logic [4:0] S_E2   = 5'd16;
    localparam logic [4:0] S_C1   = 5'd17;
    localparam logic [4:0] S_C2   = 5'd18;
    localparam logic [4:0] S_C3   = 5'd19;
    localparam logic [4:0] S_C4   = 5'd20;
    localparam logic [4:0] S_FM   = 5'd21;
    localparam logic [4:0] S_FD   = 5'd22;
    localparam logic [4:0] S_DONE = 5'd23;

    logic [4:0]   state_reg,  state_next;
    logic         wait_reg,   wait_next;
    logic [31:0]  least_reg,  least_next;
    logic         ovalid_reg, ovalid_next;

    item_t        item_reg,   item_next;
    logic [34:0]  ri_reg,     ri_next;
    logic [34:0]  rj_reg,     rj_next;
    logic [63:0]  rsq_reg,    rsq_next;
    logic [31:0]  r_reg,      r_next;
    logic         exact_reg,  exact_next;
    logic         touch_reg,  touch_next;
    logic [35:0]  rcut_reg,   rcut_next;
    logic [35:0]  delta_reg,  delta_next;
    logic [63:0]  rgeom_reg,  rgeom_next;
    logic [127:0] prod_reg,   prod_next;
    logic [63:0]  root_reg,   root_next;
    logic [63:0]  chain_reg,  chain_next;
    logic [63:0]  force_reg,  force_next;
    logic [46:0]  energy_reg, energy_next;
    logic [31:0]  crit_reg,   crit_next;
    logic [1:0]   axis_reg,   axis_next;
    logic [47:0]  fx_reg,     fx_next;
    logic [47:0]  fy_reg,     fy_next;
    logic [47:0]  fz_reg,     fz_next;

    logic         otouch_reg,  otouch_next;
    logic [47:0]  ofx_reg,     ofx_next;
    logic [47:0]  ofy_reg,     ofy_next;
    logic [47:0]  ofz_reg,     ofz_next;
    logic [46:0]  oenergy_reg, oenergy_next;
    logic [31:0]  ocrit_reg,   ocrit_next;
    logic [31:0]  omin_reg,    omin_next;

    iter_cmd_t    it_cmd;
    logic         it_start;
    logic         it_done;
    logic [127:0] it_res;
    logic         it_rem_zero;
    logic         issue;

    logic [46:0]  scale_prod;
    logic [35:0]  rcut_full;
    logic [34:0]  rcut_half;
    logic         touch_base;
    logic [35:0]  rcut_eff;
    logic         touch_eff;
    logic [31:0]  axis_mag;
    logic         axis_neg;
    logic [46:0]  fq;
    logic [47:0]  fq_signed;
    logic [63:0]  step_full;
    logic [63:0]  energy_full;
    logic [31:0]  least_upd;
    logic         out_free;

    hcpf_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (it_start),
        .cmd      (it_cmd),
        .done     (it_done),
        .res      (it_res),
        .rem_zero (it_rem_zero)
    );

    assign scale_prod = contact_scale
                        * ((state_reg == S_RI) ? item_reg.rad_first : item_reg.rad_second);

    assign rcut_full = {1'b0, ri_reg} + {1'b0, rj_reg};
    assign rcut_half = rcut_full[35:1];
    assign touch_base = {4'd0, r_reg} < rcut_full;

    always_comb
    begin
        rcut_eff = rcut_full;
        touch_eff = touch_base;
        if (touch_base && item_reg.bonded)
        begin
            rcut_eff = {1'b0, rcut_half};
            touch_eff = ({3'd0, r_reg} < rcut_half)
                        || (({3'd0, r_reg} == rcut_half) && exact_reg);
        end
    end

    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                axis_mag = item_reg.mag_x;
                axis_neg = item_reg.neg_x;
            end
            2'd1:
            begin
                axis_mag = item_reg.mag_y;
                axis_neg = item_reg.neg_y;
            end
            default:
            begin
                axis_mag = item_reg.mag_z;
                axis_neg = item_reg.neg_z;
            end
        endcase
    end

    assign fq = (|it_res[127:47]) ? FORCE_MAX : it_res[46:0];
    assign fq_signed = axis_neg ? (48'd0 - {1'b0, fq}) : {1'b0, fq};
    assign step_full = sat_shr24(it_res);
    assign energy_full = sat_shr24(it_res);
    assign least_upd = (touch_reg && (crit_reg < least_reg)) ? crit_reg : least_reg;
    assign out_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        wait_next = wait_reg;
        least_next = least_reg;
        ovalid_next = ovalid_reg;
        item_next = item_reg;
        ri_next = ri_reg;
        rj_next = rj_reg;
        rsq_next = rsq_reg;
        r_next = r_reg;
        exact_next = exact_reg;
        touch_next = touch_reg;
        rcut_next = rcut_reg;
        delta_next = delta_reg;
        rgeom_next = rgeom_reg;
        prod_next = prod_reg;
        root_next = root_reg;
        chain_next = chain_reg;
        force_next = force_reg;
        energy_next = energy_reg;
        crit_next = crit_reg;
        axis_next = axis_reg;
        fx_next = fx_reg;
        fy_next = fy_reg;
        fz_next = fz_reg;
        otouch_next = otouch_reg;
        ofx_next = ofx_reg;
        ofy_next = ofy_reg;
        ofz_next = ofz_reg;
        oenergy_next = oenergy_reg;
        ocrit_next = ocrit_reg;
        omin_next = omin_reg;
        q_pop = 1'b0;
        issue = 1'b0;
        it_cmd.op = OP_MUL;
        it_cmd.a = 128'd0;
        it_cmd.b = 64'd0;
        it_cmd.count = MUL_STEPS;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    item_next = q_item;
                    if (q_item.sweep)
                        least_next = STEP_MAX;
                    state_next = S_RI;
                end
            end
            S_RI:
            begin
                ri_next = scale_prod[46:12];
                state_next = S_RJ;
            end
            S_RJ:
            begin
                rj_next = scale_prod[46:12];
                state_next = S_SQX;
            end
            S_SQX:
            begin
                issue = 1'b1;
                it_cmd.a = {96'd0, item_reg.mag_x};
                it_cmd.b = {32'd0, item_reg.mag_x};
                if (it_done)
                begin
                    rsq_next = it_res[63:0];
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                issue = 1'b1;
                it_cmd.a = {96'd0, item_reg.mag_y};
                it_cmd.b = {32'd0, item_reg.mag_y};
                if (it_done)
                begin
                    rsq_next = rsq_reg + it_res[63:0];
                    state_next = S_SQZ;
                end
            end
            S_SQZ:
            begin
                issue = 1'b1;
                it_cmd.a = {96'd0, item_reg.mag_z};
                it_cmd.b = {32'd0, item_reg.mag_z};
                if (it_done)
                begin
                    rsq_next = rsq_reg + it_res[63:0];
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                issue = 1'b1;
                it_cmd.op = OP_SQRT;
                it_cmd.a = {rsq_reg, 64'd0};
                it_cmd.count = ROOT32_STEPS;
                if (it_done)
                begin
                    r_next = it_res[31:0];
                    exact_next = it_rem_zero;
                    state_next = S_CUT;
                end
            end
            S_CUT:
            begin
                rcut_next = rcut_eff;
                delta_next = rcut_eff - {4'd0, r_reg};
                touch_next = touch_eff;
                if (!touch_eff)
                    state_next = S_DONE;
                else if (rcut_eff == 36'd0)
                begin
                    rgeom_next = 64'd0;
                    state_next = S_PDR;
                end
                else
                    state_next = S_PRR;
            end
            S_PRR:
            begin
                issue = 1'b1;
                it_cmd.a = {93'd0, ri_reg};
                it_cmd.b = {29'd0, rj_reg};
                if (it_done)
                begin
                    prod_next = it_res;
                    state_next = S_DRG;
                end
            end
            S_DRG:
            begin
                issue = 1'b1;
                it_cmd.op = OP_DIV;
                it_cmd.a = {prod_reg[71:0], 56'd0};
                it_cmd.b = {28'd0, rcut_reg};
                it_cmd.count = DIV_RGEOM_STEPS;
                if (it_done)
                begin
                    rgeom_next = (|it_res[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : it_res[63:0];
                    state_next = S_PDR;
                end
            end
            S_PDR:
            begin
                issue = 1'b1;
                it_cmd.a = {92'd0, delta_reg};
                it_cmd.b = rgeom_reg;
                if (it_done)
                begin
                    prod_next = it_res;
                    state_next = S_RTG;
                end
            end
            S_RTG:
            begin
                issue = 1'b1;
                it_cmd.op = OP_SQRT;
                it_cmd.a = prod_reg;
                it_cmd.count = ROOT64_STEPS;
                if (it_done)
                begin
                    root_next = it_res[63:0];
                    state_next = S_F1;
                end
            end
            S_F1:
            begin
                issue = 1'b1;
                it_cmd.a = {96'd0, item_reg.modulus};
                it_cmd.b = {28'd0, delta_reg};
                if (it_done)
                begin
                    chain_next = sat_shr16(it_res);
                    state_next = S_F2;
                end
            end
            S_F2:
            begin
                issue = 1'b1;
                it_cmd.a = {64'd0, chain_reg};
                it_cmd.b = root_reg;
                if (it_done)
                begin
                    chain_next = sat_shr24(it_res);
                    state_next = S_F3;
                end
            end
            S_F3:
            begin
                issue = 1'b1;
                it_cmd.a = {64'd0, chain_reg};
                it_cmd.b = K_HERTZ;
                if (it_done)
                begin
                    force_next = sat_shr24(it_res);
                    state_next = S_E1;
                end
            end
            S_E1:
            begin
                issue = 1'b1;
                it_cmd.a = {64'd0, force_reg};
                it_cmd.b = {28'd0, delta_reg};
                if (it_done)
                begin
                    chain_next = sat_shr24(it_res);
                    state_next = S_E2;
                end
            end
            S_E2:
            begin
                issue = 1'b1;
                it_cmd.a = {64'd0, chain_reg};
                it_cmd.b = K_ENERGY;
                if (it_done)
                begin
                    energy_next = (|energy_full[63:47]) ? FORCE_MAX : energy_full[46:0];
                    state_next = S_C1;
                end
            end
            S_C1:
            begin
                if (force_reg == 64'd0)
                begin
                    crit_next = STEP_MAX;
                    axis_next = 2'd0;
                    state_next = S_FM;
                end
                else
                begin
                    issue = 1'b1;
                    it_cmd.a = {96'd0, item_reg.mass};
                    it_cmd.b = {28'd0, delta_reg};
                    if (it_done)
                    begin
                        prod_next = it_res;
                        state_next = S_C2;
                    end
                end
            end
            S_C2:
            begin
                issue = 1'b1;
                it_cmd.op = OP_DIV;
                it_cmd.a = {prod_reg[68:0], 59'd0};
                it_cmd.b = force_reg;
                it_cmd.count = DIV_STEP_STEPS;
                if (it_done)
                begin
                    prod_next = it_res;
                    state_next = S_C3;
                end
            end
            S_C3:
            begin
                issue = 1'b1;
                it_cmd.op = OP_SQRT;
                it_cmd.a = prod_reg;
                it_cmd.count = ROOT64_STEPS;
                if (it_done)
                begin
                    chain_next = it_res[63:0];
                    state_next = S_C4;
                end
            end
            S_C4:
            begin
                issue = 1'b1;
                it_cmd.a = {64'd0, chain_reg};
                it_cmd.b = K_PI;
                if (it_done)
                begin
                    crit_next = (|step_full[63:32]) ? STEP_MAX : step_full[31:0];
                    axis_next = 2'd0;
                    state_next = S_FM;
                end
            end
            S_FM:
            begin
                if (r_reg == 32'd0)
                begin
                    unique case (axis_reg)
                        2'd0:    fx_next = 48'd0;
                        2'd1:    fy_next = 48'd0;
                        default: fz_next = 48'd0;
                    endcase
                    axis_next = axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                        state_next = S_DONE;
                end
                else
                begin
                    issue = 1'b1;
                    it_cmd.a = {96'd0, axis_mag};
                    it_cmd.b = force_reg;
                    if (it_done)
                    begin
                        prod_next = it_res;
                        state_next = S_FD;
                    end
                end
            end
            S_FD:
            begin
                issue = 1'b1;
                it_cmd.op = OP_DIV;
                it_cmd.a = {prod_reg[95:0], 32'd0};
                it_cmd.b = {32'd0, r_reg};
                it_cmd.count = DIV_FORCE_STEPS;
                if (it_done)
                begin
                    unique case (axis_reg)
                        2'd0:    fx_next = fq_signed;
                        2'd1:    fy_next = fq_signed;
                        default: fz_next = fq_signed;
                    endcase
                    axis_next = axis_reg + 2'd1;
                    state_next = (axis_reg == 2'd2) ? S_DONE : S_FM;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    otouch_next = touch_reg;
                    ofx_next = touch_reg ? fx_reg : 48'd0;
                    ofy_next = touch_reg ? fy_reg : 48'd0;
                    ofz_next = touch_reg ? fz_reg : 48'd0;
                    oenergy_next = touch_reg ? energy_reg : 47'd0;
                    ocrit_next = touch_reg ? crit_reg : STEP_MAX;
                    least_next = least_upd;
                    omin_next = least_upd;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        it_start = issue && !wait_reg;
        if (it_start)
            wait_next = 1'b1;
        else if (it_done)
            wait_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg <= 1'b0;
            least_reg <= STEP_MAX;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg <= wait_next;
            least_reg <= least_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        ri_reg <= ri_next;
        rj_reg <= rj_next;
        rsq_reg <= rsq_next;
        r_reg <= r_next;
        exact_reg <= exact_next;
        touch_reg <= touch_next;
        rcut_reg <= rcut_next;
        delta_reg <= delta_next;
        rgeom_reg <= rgeom_next;
        prod_reg <= prod_next;
        root_reg <= root_next;
        chain_reg <= chain_next;
        force_reg <= force_next;
        energy_reg <= energy_next;
        crit_reg <= crit_next;
        axis_reg <= axis_next;
        fx_reg <= fx_next;
        fy_reg <= fy_next;
        fz_reg <= fz_next;
        otouch_reg <= otouch_next;
        ofx_reg <= ofx_next;
        ofy_reg <= ofy_next;
        ofz_reg <= ofz_next;
        oenergy_reg <= oenergy_next;
        ocrit_reg <= ocrit_next;
        omin_reg <= omin_next;
    end

    assign out_valid = ovalid_reg;
    assign touching = otouch_reg;
    assign force_x = ofx_reg;
    assign force_y = ofy_reg;
    assign force_z = ofz_reg;
    assign pair_energy = oenergy_reg;
    assign crit_step = ocrit_reg;
    assign min_step = omin_reg;

endmodule

[rtl/hertz_contact_pair_force.sv]
// Top level of the Hertz contact pair force block.
//
// Usage: one request per neighbor pair on the input channel (in_valid/in_stall),
// one result per request on the output channel (out_valid/out_stall), in order.
// contact_scale is written over cfg_valid/cfg_ready (always ready); the user
// must write it only while idle; the block itself does not enforce this.
// The sequencer works on one pair at a time and steps it through the single
// shared iterative unit (4 partial products per multiply, one quotient bit or
// one root bit per cycle); a pair out of contact skips the later steps.
// A two-entry queue plus one front register take up to three requests ahead of
// the sequencer, so the input side keeps accepting while a pair is worked on.
// A result waits in the output register while out_stall is high; the next
// pair is computed meanwhile and held until the register frees.
// Reset: queue and outputs empty, contact_scale = 1.0 (Q4.12), running
// minimum time step = all ones.
`timescale 1ns / 1ps

module hertz_contact_pair_force
    import hcpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] sep_x,
    input  logic signed [31:0] sep_y,
    input  logic signed [31:0] sep_z,
    input  logic [30:0]        radius_first,
    input  logic [30:0]        radius_second,
    input  logic               same_kind,
    input  logic [31:0]        init_dist_sq,
    input  logic [30:0]        sph_sum,
    input  logic [31:0]        mass_sum,
    input  logic [31:0]        modulus,
    input  logic               sweep_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               touching,
    output logic signed [47:0] force_x,
    output logic signed [47:0] force_y,
    output logic signed [47:0] force_z,
    output logic [46:0]        pair_energy,
    output logic [31:0]        crit_step,
    output logic [31:0]        min_step
);

    logic [15:0] scale_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    item_t       push_item;
    item_t       head_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_valid && cfg_ready)
            scale_reg <= cfg_data;
    end

    hcpf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sep_x         (sep_x),
        .sep_y         (sep_y),
        .sep_z         (sep_z),
        .radius_first  (radius_first),
        .radius_second (radius_second),
        .same_kind     (same_kind),
        .init_dist_sq  (init_dist_sq),
        .sph_sum       (sph_sum),
        .mass_sum      (mass_sum),
        .modulus       (modulus),
        .sweep_start   (sweep_start),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    hcpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    hcpf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .contact_scale (scale_reg),
        .q_valid       (q_not_empty),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .touching      (touching),
        .force_x       (force_x),
        .force_y       (force_y),
        .force_z       (force_z),
        .pair_energy   (pair_energy),
        .crit_step     (crit_step),
        .min_step      (min_step)
    );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the Hertz contact pair force block.
`timescale 1ns / 1ps

module testbench;
    import hcpf_pkg::*;

    typedef struct packed {
        logic [31:0] sx, sy, sz;
        logic [30:0] rad1, rad2;
        logic        same;
        logic [31:0] init_sq;
        logic [30:0] sph;
        logic [31:0] mass, bulk;
        logic        sweep;
    } pair_t;

    typedef struct packed {
        logic        touch;
        logic [47:0] fx, fy, fz;
        logic [46:0] energy;
        logic [31:0] crit, least;
    } contact_t;

    class contact_scoreboard;
        logic [15:0] scale;
        logic [31:0] least;
        contact_t    due[$];
        int          errors;

        function new();
            scale = SCALE_RESET;
            least = STEP_MAX;
            errors = 0;
        endfunction

        function logic [63:0] isqrt(logic [127:0] x);
            logic [63:0] res, c;
            res = 0;
            for (int b = 63; b >= 0; b--)
            begin
                c = res | (64'd1 << b);
                if (128'(c) * 128'(c) <= x)
                    res = c;
            end
            return res;
        endfunction

        function logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
            logic [127:0] p;
            p = 128'(a) * 128'(b);
            if ((p >> (64 + sh)) != 0)
                return '1;
            return 64'(p >> sh);
        endfunction

        function contact_t contact_force(pair_t p);
            contact_t    o;
            logic [31:0] mag[3];
            logic        neg[3];
            logic [31:0] sep[3];
            logic [63:0] rsq, r, ri, rj, rcut, h, delta, rgeom, root, fmag, energy, crit;
            logic [127:0] q, num;
            sep[0] = p.sx;
            sep[1] = p.sy;
            sep[2] = p.sz;
            for (int k = 0; k < 3; k++)
            begin
                neg[k] = sep[k][31];
                mag[k] = neg[k] ? (~sep[k] + 32'd1) : sep[k];
            end
            if (p.sweep)
                least = STEP_MAX;
            o.touch = 0;
            o.fx = 0;
            o.fy = 0;
            o.fz = 0;
            o.energy = 0;
            o.crit = STEP_MAX;
            rsq = 64'(mag[0]) * 64'(mag[0]) + 64'(mag[1]) * 64'(mag[1])
                + 64'(mag[2]) * 64'(mag[2]);
            r = isqrt(128'(rsq));
            ri = (64'(scale) * 64'(p.rad1)) >> 12;
            rj = (64'(scale) * 64'(p.rad2)) >> 12;
            rcut = ri + rj;
            o.touch = r < rcut;
            if (o.touch && p.same && ((64'(p.init_sq) << 24) < 64'(p.sph) * 64'(p.sph)))
            begin
                h = rcut >> 1;
                o.touch = (r < h) || (r == h && r * r == rsq);
                rcut = h;
            end
            if (!o.touch)
            begin
                o.least = least;
                return o;
            end
            delta = rcut - r;
            if (rcut == 0)
                rgeom = 0;
            else
            begin
                q = (128'(ri) * 128'(rj)) / 128'(rcut);
                rgeom = (q[127:64] != 0) ? '1 : q[63:0];
            end
            root = isqrt(128'(delta) * 128'(rgeom));
            fmag = mulsh(mulsh(mulsh(64'(p.bulk), delta, 16), root, 24), K_HERTZ, 24);
            energy = mulsh(mulsh(fmag, delta, 24), K_ENERGY, 24);
            if (energy > 64'(FORCE_MAX))
                energy = 64'(FORCE_MAX);
            if (fmag == 0)
                crit = 64'(STEP_MAX);
            else
            begin
                num = (128'(p.mass) * 128'(delta)) << 31;
                crit = mulsh(isqrt(num / 128'(fmag)), K_PI, 24);
                if (crit > 64'(STEP_MAX))
                    crit = 64'(STEP_MAX);
            end
            if (crit[31:0] < least)
                least = crit[31:0];
            for (int k = 0; k < 3; k++)
            begin
                logic [47:0] f;
                f = 0;
                if (r != 0)
                begin
                    q = (128'(mag[k]) * 128'(fmag)) / 128'(r);
                    f = (q > 128'(FORCE_MAX)) ? 48'(FORCE_MAX) : q[47:0];
                end
                if (neg[k])
                    f = ~f + 48'd1;
                if (k == 0) o.fx = f;
                else if (k == 1) o.fy = f;
                else o.fz = f;
            end
            o.energy = energy[46:0];
            o.crit = crit[31:0];
            o.least = least;
            return o;
        endfunction

        function void note_request(pair_t p);
            due.push_back(contact_force(p));
        endfunction

        function void check_result(contact_t got);
            contact_t want;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result at %0t", $realtime);
                return;
            end
            want = due.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at %0t: exp t=%0b f=%h/%h/%h e=%h c=%h m=%h got t=%0b f=%h/%h/%h e=%h c=%h m=%h",
                        $realtime, want.touch, want.fx, want.fy, want.fz, want.energy,
                        want.crit, want.least, got.touch, got.fx, got.fy, got.fz,
                        got.energy, got.crit, got.least);
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [15:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [31:0] sep_x, sep_y, sep_z;
    logic [30:0] radius_first, radius_second, sph_sum;
    logic same_kind, sweep_start, touching;
    logic [31:0] init_dist_sq, mass_sum, modulus, crit_step, min_step;
    logic signed [47:0] force_x, force_y, force_z;
    logic [46:0] pair_energy;

    contact_scoreboard sb = new();
    int sent = 0;
    int idle = 0;
    bit held = 0;

    hertz_contact_pair_force u_top (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request('{sep_x, sep_y, sep_z, radius_first, radius_second, same_kind,
                    init_dist_sq, sph_sum, mass_sum, modulus, sweep_start});
            if (out_valid && !out_stall)
                sb.check_result('{touching, force_x, force_y, force_z, pair_energy,
                    crit_step, min_step});
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle <= 0;
            else
                idle <= idle + 1;
            if (idle > IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off to back the block up
    initial
    begin
        int mode, len;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(1, 300);
            if (mode == 3 && !held && sent > 60)
            begin
                held = 1;
                len = 4000;
            end
            repeat (len)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(0, 1));
                    2: out_stall <= ($urandom_range(0, 7) != 0);
                    default: out_stall <= held && len == 4000;
                endcase
            end
        end
    end

    task automatic send_pair(pair_t p);
        in_valid <= 1'b1;
        sep_x <= p.sx;
        sep_y <= p.sy;
        sep_z <= p.sz;
        radius_first <= p.rad1;
        radius_second <= p.rad2;
        same_kind <= p.same;
        init_dist_sq <= p.init_sq;
        sph_sum <= p.sph;
        mass_sum <= p.mass;
        modulus <= p.bulk;
        sweep_start <= p.sweep;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
    endtask

    task automatic write_scale(logic [15:0] v);
        wait (sb.due.size() == 0);
        repeat (1000) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.scale = v;
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        int span;
        p.sweep = ($urandom_range(0, 9) == 0);
        p.same = 1'($urandom_range(0, 1));
        p.mass = $urandom();
        p.bulk = $urandom();
        if ($urandom_range(0, 4) == 0)
        begin
            p.sx = $urandom();
            p.sy = $urandom();
            p.sz = $urandom();
            p.rad1 = 31'($urandom());
            p.rad2 = 31'($urandom());
            p.init_sq = $urandom();
            p.sph = 31'($urandom());
            return p;
        end
        p.rad1 = 31'($urandom_range(1 << 20, 1 << 26));
        p.rad2 = 31'($urandom_range(1 << 20, 1 << 26));
        span = (p.rad1 + p.rad2) / 2;
        p.sx = $urandom_range(0, 2 * span) - span;
        p.sy = $urandom_range(0, 2 * span) - span;
        p.sz = $urandom_range(0, 2 * span) - span;
        p.sph = 31'($urandom_range(1 << 22, 1 << 27));
        p.init_sq = $urandom_range(0, 1) ? $urandom_range(0, 1 << 26) : $urandom();
        if ($urandom_range(0, 7) == 0)
            p.bulk = $urandom_range(0, 3);
        return p;
    endfunction

    task automatic random_run(int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && n > 0; i++, n--)
                send_pair(random_pair());
            if ($urandom_range(0, 3) != 0)
                pause_sender();
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        pair_t d[$];
        logic [15:0] scales[4];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 0;
        in_valid = 1'b0;
        sep_x = 0;
        sep_y = 0;
        sep_z = 0;
        radius_first = 0;
        radius_second = 0;
        same_kind = 0;
        init_dist_sq = 0;
        sph_sum = 0;
        mass_sum = 0;
        modulus = 0;
        sweep_start = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        d.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1});
        d.push_back('{'1, '1, '1, '1, '1, 1, '1, '1, '1, '1, 1});
        d.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1, 0, 0, 0,
            '1, '1, 0});
        d.push_back('{0, 0, 0, 1 << 24, 1 << 24, 0, 0, 0, 1 << 16, 1 << 16, 0});
        d.push_back('{32'h0040_0000, 32'hFFC0_0000, 32'h0010_0000, 1 << 24, 1 << 23, 0,
            0, 0, 1 << 16, 1 << 20, 0});
        d.push_back('{1 << 24, 0, 0, 1 << 24, 1 << 24, 1, 0, 1, 1 << 16, 1 << 16, 0});
        d.push_back('{32'h00F0_0000, 0, 0, 1 << 24, 1 << 24, 1, 0, 1 << 26, 1 << 16,
            1 << 16, 0});
        d.push_back('{32'h0080_0000, 0, 0, 1 << 24, 1 << 24, 1, '1, 1 << 26, 1 << 16,
            1 << 16, 0});
        d.push_back('{32'h0080_0000, 0, 0, 1 << 24, 1 << 24, 0, 0, 1 << 26, 1 << 16, 0, 0});
        d.push_back('{32'h0080_0000, 0, 0, 1 << 24, 1 << 24, 0, 0, 0, 0, '1, 0});
        d.push_back('{32'hFF80_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1 << 24, 1 << 24, 0,
            0, 0, '1, 1, 1});
        d.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, 0, 0, 0,
            1, '1, 0});
        d.push_back('{1, 1, 1, '1, '1, 0, 0, 0, 1, '1, 0});
        d.push_back('{0, 0, 0, 1, 0, 0, 0, 0, '1, '1, 0});
        foreach (d[i])
            send_pair(d[i]);
        in_valid <= 1'b0;
        random_run(236);

        scales[0] = 16'd0;
        scales[1] = 16'hFFFF;
        scales[2] = 16'd2048;
        scales[3] = 16'($urandom_range(1, 65535));
        foreach (scales[i])
        begin
            write_scale(scales[i]);
            random_run(scales[i] == 0 ? 50 : 150);
        end

        wait (sb.due.size() == 0);
        repeat (1000) @(posedge clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/hcpf_pkg.sv
rtl/hcpf_iter.sv
rtl/hcpf_front.sv
rtl/hcpf_queue.sv
rtl/hcpf_back.sv
rtl/hertz_contact_pair_force.sv
tb/sv/testbench.sv
